// ----- rtl/stfl_pkg.sv -----
// Shared types, codes and constants for the sorted table floor lookup.
package stfl_pkg;

   // Field widths of the request and response channels
   localparam int OP_W     = 2;
   localparam int ADDR_W   = 32;
   localparam int STATUS_W = 3;
   localparam int INDEX_W  = 12;

   // Default number of table entries
   localparam int TABLE_DEPTH_DEFAULT = 4096;

   // Entries in the command queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // Request operation codes
   typedef enum logic [OP_W-1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_LOOKUP = 2'd2
   } stfl_op_type;

   // Response status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_DONE      = 3'd0,
      ST_ZERO      = 3'd1,
      ST_FULL      = 3'd2,
      ST_EXACT     = 3'd3,
      ST_PRECEDING = 3'd4,
      ST_NOT_FOUND = 3'd5
   } stfl_status_type;

   // Command kinds after classification in the front end
   typedef enum logic [1:0] {
      K_CLEAR,
      K_APPEND,
      K_ZERO,
      K_LOOKUP
   } stfl_kind_type;

   // Command as it sits in the queue
   typedef struct packed {
      stfl_kind_type     kind;
      logic [ADDR_W-1:0] value;
   } stfl_cmd_type;

   // Back end sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_PROBE,
      S_UPPER,
      S_LOWER,
      S_EMIT
   } stfl_state_type;

endpackage

// ----- rtl/stfl_if.sv -----
// Valid/ready channel interfaces for requests and responses.
interface stfl_req_if;
   import stfl_pkg::*;

   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   logic [ADDR_W-1:0] address_value;

   modport source (output valid, output operation, output address_value, input ready);
   modport sink   (input valid, input operation, input address_value, output ready);
endinterface

interface stfl_rsp_if;
   import stfl_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [INDEX_W-1:0]  entry_index;
   logic [ADDR_W-1:0]   entry_address;

   modport source (output valid, output status, output entry_index, output entry_address,
                   input ready);
   modport sink   (input valid, input status, input entry_index, input entry_address,
                   output ready);
endinterface

// ----- rtl/stfl_ram.sv -----
// Generic simple dual-port RAM with registered read.
module stfl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

// ----- rtl/stfl_front.sv -----
// Front end: takes requests, classifies them and drops the unused code.
module stfl_front (
   stfl_req_if.sink             req_chan,
   output logic                 cmd_valid,
   input  logic                 cmd_ready,
   output stfl_pkg::stfl_cmd_type cmd
);
   import stfl_pkg::*;

   logic keep;

   // A request transfers whenever the queue has room
   assign req_chan.ready = cmd_ready;

   // Classify; a zero append is settled here so the back end skips the table
   always_comb begin
      keep      = 1'b1;
      cmd.value = req_chan.address_value;
      cmd.kind  = K_CLEAR;
      unique case (req_chan.operation)
         OP_CLEAR:  cmd.kind = K_CLEAR;
         OP_APPEND: cmd.kind = (req_chan.address_value == '0) ? K_ZERO : K_APPEND;
         OP_LOOKUP: cmd.kind = K_LOOKUP;
         default:   keep = 1'b0;
      endcase
   end

   assign cmd_valid = req_chan.valid && keep;

endmodule

// ----- rtl/stfl_queue.sv -----
// Short command queue between front end and back end.
module stfl_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   output logic                   push_ready,
   input  stfl_pkg::stfl_cmd_type push_data,
   output logic                   pop_valid,
   input  logic                   pop_ready,
   output stfl_pkg::stfl_cmd_type pop_data
);
   import stfl_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   stfl_cmd_type    slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   fill_ff, fill_in;
   logic            do_push, do_pop;

   assign push_ready = (fill_ff != CW'(QUEUE_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and fill updates
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/stfl_back.sv -----
// Back end: owns the table and entry count, runs clears, appends and searches.
module stfl_back #(
   parameter int TABLE_DEPTH = stfl_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_valid,
   output logic                   cmd_ready,
   input  stfl_pkg::stfl_cmd_type cmd,
   stfl_rsp_if.source             rsp_chan
);
   import stfl_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int XW    = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

   stfl_state_type      state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [ADDR_W-1:0]   query_ff, query_in;
   logic [CNT_W-1:0]    lo_ff, lo_in;
   logic [CNT_W-1:0]    hx_ff, hx_in;      // one past the upper bound
   logic [CNT_W-1:0]    mid_ff, mid_in;
   stfl_status_type     res_status_ff, res_status_in;
   logic [CNT_W-1:0]    res_idx_ff, res_idx_in;
   logic [ADDR_W-1:0]   res_addr_ff, res_addr_in;
   logic                out_valid_ff, out_valid_in;
   stfl_status_type     out_status_ff, out_status_in;
   logic [INDEX_W-1:0]  out_index_ff, out_index_in;
   logic [ADDR_W-1:0]   out_addr_ff, out_addr_in;

   logic                ram_we, ram_re;
   logic [CNT_W-1:0]    ram_raddr;
   logic [ADDR_W-1:0]   ram_rdata;

   logic [CNT_W-1:0]    nlo, nhx, nmid;
   logic [CNT_W:0]      msum;
   logic [XW-1:0]       idx_ext;
   logic                out_free;

   stfl_ram #(
      .WIDTH (ADDR_W),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock      (clock),
      .wr_en      (ram_we),
      .wr_addr    (count_ff[IDX_W-1:0]),
      .wr_data    (cmd.value),
      .rd_en      (ram_re),
      .rd_addr    (ram_raddr[IDX_W-1:0]),
      .rd_data_ff (ram_rdata)
   );

   // Narrowing step for the probe that just came back
   always_comb begin
      if (ram_rdata > query_ff) begin
         nlo = lo_ff;
         nhx = mid_ff;
      end else begin
         nlo = mid_ff + 1'b1;
         nhx = hx_ff;
      end
      msum = {1'b0, nlo} + {1'b0, nhx} - 1'b1;
      nmid = msum[CNT_W:1];
   end

   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign idx_ext  = XW'(res_idx_ff);

   // Sequencer: next state, table access and result capture
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      query_in      = query_ff;
      lo_in         = lo_ff;
      hx_in         = hx_ff;
      mid_in        = mid_ff;
      res_status_in = res_status_ff;
      res_idx_in    = res_idx_ff;
      res_addr_in   = res_addr_ff;
      out_valid_in  = out_valid_ff;
      out_status_in = out_status_ff;
      out_index_in  = out_index_ff;
      out_addr_in   = out_addr_ff;
      cmd_ready     = 1'b0;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      ram_raddr     = '0;

      if (out_valid_ff && rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_ready     = 1'b1;
               res_status_in = ST_DONE;
               res_idx_in    = '0;
               res_addr_in   = '0;
               state_in      = S_EMIT;
               unique case (cmd.kind)
                  K_CLEAR: count_in = '0;
                  K_ZERO:  res_status_in = ST_ZERO;
                  K_APPEND: begin
                     if (count_ff == CNT_W'(TABLE_DEPTH)) begin
                        res_status_in = ST_FULL;
                     end else begin
                        ram_we   = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  K_LOOKUP: begin
                     query_in = cmd.value;
                     if (count_ff == '0) begin
                        res_status_in = ST_NOT_FOUND;
                     end else begin
                        lo_in     = '0;
                        hx_in     = count_ff;
                        mid_in    = (count_ff - 1'b1) >> 1;
                        ram_re    = 1'b1;
                        ram_raddr = (count_ff - 1'b1) >> 1;
                        state_in  = S_PROBE;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end

         // Entry at mid is on the read port
         S_PROBE: begin
            if (ram_rdata == query_ff) begin
               res_status_in = ST_EXACT;
               res_idx_in    = mid_ff;
               res_addr_in   = ram_rdata;
               state_in      = S_EMIT;
            end else if (nlo < nhx) begin
               lo_in     = nlo;
               hx_in     = nhx;
               mid_in    = nmid;
               ram_re    = 1'b1;
               ram_raddr = nmid;
            end else begin
               lo_in = nlo;
               if (nlo != '0 && nlo != count_ff) begin
                  ram_re    = 1'b1;
                  ram_raddr = nlo;
                  state_in  = S_UPPER;
               end else begin
                  res_status_in = ST_NOT_FOUND;
                  res_idx_in    = '0;
                  res_addr_in   = '0;
                  state_in      = S_EMIT;
               end
            end
         end

         // Entry at lo is on the read port: the query must sit below it
         S_UPPER: begin
            if (query_ff < ram_rdata) begin
               ram_re    = 1'b1;
               ram_raddr = lo_ff - 1'b1;
               state_in  = S_LOWER;
            end else begin
               res_status_in = ST_NOT_FOUND;
               res_idx_in    = '0;
               res_addr_in   = '0;
               state_in      = S_EMIT;
            end
         end

         // Preceding entry is on the read port
         S_LOWER: begin
            res_status_in = ST_PRECEDING;
            res_idx_in    = lo_ff - 1'b1;
            res_addr_in   = ram_rdata;
            state_in      = S_EMIT;
         end

         // Hand the result to the output register once it is free
         S_EMIT: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_status_in = res_status_ff;
               out_index_in  = idx_ext[INDEX_W-1:0];
               out_addr_in   = res_addr_ff;
               state_in      = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      query_ff      <= query_in;
      lo_ff         <= lo_in;
      hx_ff         <= hx_in;
      mid_ff        <= mid_in;
      res_status_ff <= res_status_in;
      res_idx_ff    <= res_idx_in;
      res_addr_ff   <= res_addr_in;
      out_status_ff <= out_status_in;
      out_index_ff  <= out_index_in;
      out_addr_ff   <= out_addr_in;
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.status        = out_status_ff;
   assign rsp_chan.entry_index   = out_index_ff;
   assign rsp_chan.entry_address = out_addr_ff;

endmodule

// ----- rtl/sorted_table_floor_lookup.sv -----
// Clear and append go from the queue through the idle and emit states to the response
// register; the back end takes no new command until the last has left emit. A lookup
// binary-searches the single table read port, then reads bounding entries if no match.
// A two-entry command queue lets requests transfer while the back end is busy.
// Reset (synchronous) empties the table count and the queue; table memory is
// not cleared and needs no clearing pass.
module sorted_table_floor_lookup #(
   parameter int TABLE_DEPTH = stfl_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   stfl_req_if.sink   req_chan,
   stfl_rsp_if.source rsp_chan
);
   import stfl_pkg::*;

   logic         fr_valid, fr_ready;
   stfl_cmd_type fr_cmd;
   logic         bk_valid, bk_ready;
   stfl_cmd_type bk_cmd;

   stfl_front u_front (
      .req_chan  (req_chan),
      .cmd_valid (fr_valid),
      .cmd_ready (fr_ready),
      .cmd       (fr_cmd)
   );

   stfl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fr_valid),
      .push_ready (fr_ready),
      .push_data  (fr_cmd),
      .pop_valid  (bk_valid),
      .pop_ready  (bk_ready),
      .pop_data   (bk_cmd)
   );

   stfl_back #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (bk_valid),
      .cmd_ready (bk_ready),
      .cmd       (bk_cmd),
      .rsp_chan  (rsp_chan)
   );

endmodule

// ----- rtl/stfl_checker.sv -----
// Port-level checks for the floor lookup, bound to the top level.
module stfl_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [stfl_pkg::STATUS_W-1:0] rsp_status,
   input logic [stfl_pkg::INDEX_W-1:0]  rsp_entry_index,
   input logic [stfl_pkg::ADDR_W-1:0]   rsp_entry_address
);
   import stfl_pkg::*;

   // A stalled response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_entry_index) && $stable(rsp_entry_address))
      else $error("stalled response changed");

   // Only defined status codes leave the block
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= ST_NOT_FOUND))
      else $error("undefined status code");

   // Results without a matched entry carry zero index and address
   a_no_match_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_DONE || rsp_status == ST_ZERO
         || rsp_status == ST_FULL || rsp_status == ST_NOT_FOUND)
      |-> (rsp_entry_index == '0) && (rsp_entry_address == '0))
      else $error("nonzero entry on a result without a match");

   // A matched entry was appended, so it is never zero
   a_match_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_EXACT || rsp_status == ST_PRECEDING)
      |-> (rsp_entry_address != '0))
      else $error("matched entry has zero address");

endmodule

bind sorted_table_floor_lookup stfl_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_status        (rsp_chan.status),
   .rsp_entry_index   (rsp_chan.entry_index),
   .rsp_entry_address (rsp_chan.entry_address)
);
